// ----- hdl/kplc_pkg.sv -----
// ----------------------------------------------------------------------------
// kplc_pkg
// shared widths, mode codes, event codes, function codes, register indices and key codes
// for the keypad pin lock controller
// ----------------------------------------------------------------------------
package kplc_pkg;

  localparam int MAX_PIN_DIGITS = 16;

  localparam int FUNC_W   = 3;
  localparam int KEY_W    = 8;
  localparam int MS_W     = 31;
  localparam int EVENT_W  = 4;
  localparam int COUNT8_W = 8;
  localparam int ANGLE_W  = 8;
  localparam int MODE_W   = 2;
  localparam int PIN_W    = 64;
  localparam int PLEN_W   = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [MODE_W-1:0] MODE_LOCKED   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_UNLOCKED = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LOCKOUT  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_ALARM    = 2'd3;

  localparam logic [FUNC_W-1:0] FUNC_KEY         = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_DOOR_OPEN   = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_REMOTE_OPEN = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_REMOTE_CLR  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_TICK        = 3'd4;

  localparam logic [EVENT_W-1:0] EV_UNLOCK_PIN    = 4'd0;
  localparam logic [EVENT_W-1:0] EV_ALARM_CLR_PIN = 4'd1;
  localparam logic [EVENT_W-1:0] EV_WRONG_PIN     = 4'd2;
  localparam logic [EVENT_W-1:0] EV_LOCKOUT       = 4'd3;
  localparam logic [EVENT_W-1:0] EV_INTRUSION     = 4'd4;
  localparam logic [EVENT_W-1:0] EV_ENTRY         = 4'd5;
  localparam logic [EVENT_W-1:0] EV_REMOTE_DENIED = 4'd6;
  localparam logic [EVENT_W-1:0] EV_UNLOCK_REMOTE = 4'd7;
  localparam logic [EVENT_W-1:0] EV_ALARM_CLR_REM = 4'd8;
  localparam logic [EVENT_W-1:0] EV_RELOCKED      = 4'd9;
  localparam logic [EVENT_W-1:0] EV_LOCKOUT_CLR   = 4'd10;

  localparam logic [CFG_IDX_W-1:0] REG_PIN_CODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PIN_LENGTH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ATTEMPTS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT_TIME = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNLOCK_TIME  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CLOSED_ANGLE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OPEN_ANGLE   = 3'd6;

  localparam logic [KEY_W-1:0] KEY_STAR = 8'h2A;
  localparam logic [KEY_W-1:0] KEY_HASH = 8'h23;
  localparam logic [KEY_W-1:0] KEY_0    = 8'h30;
  localparam logic [KEY_W-1:0] KEY_9    = 8'h39;

endpackage

// ----- hdl/keypad_pin_lock_controller.sv -----
// ----------------------------------------------------------------------------
// keypad_pin_lock_controller
// door lock controller: pin entry, wrong pin lockout, alarm, relock timers
//
//   channel  direction  handshake                 payload
//   in       sink       in_valid_i / in_stall_o   func, key_char, elapsed_ms
//   out      source     out_valid_o / out_stall_i event_code .. last
//   cfg      sink       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// the results of a taken item show from the next cycle on
// an item with two results holds the input for one extra output beat
// a new item is taken in the same cycle the last pending beat leaves
// reset gives locked mode, empty entry, cleared timers, default registers
// the configuration port is always ready
// ----------------------------------------------------------------------------
module keypad_pin_lock_controller #(
  parameter int MaxPinDigits = kplc_pkg::MAX_PIN_DIGITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [kplc_pkg::FUNC_W-1:0]       func_i,
  input  logic [kplc_pkg::KEY_W-1:0]        key_char_i,
  input  logic [kplc_pkg::MS_W-1:0]         elapsed_ms_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [kplc_pkg::EVENT_W-1:0]      event_code_o,
  output logic [kplc_pkg::COUNT8_W-1:0]     attempts_left_o,
  output logic [kplc_pkg::MS_W-1:0]         lockout_report_o,
  output logic [kplc_pkg::ANGLE_W-1:0]      bolt_angle_o,
  output logic [kplc_pkg::MODE_W-1:0]       lock_mode_o,
  output logic                              last_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [kplc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [kplc_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import kplc_pkg::*;

  localparam int DigitsW = 4 * MaxPinDigits;
  localparam int CntW    = $clog2(MaxPinDigits + 1);

  // configuration
  logic [PIN_W-1:0]    pin_code_q;
  logic [PLEN_W-1:0]   pin_length_q;
  logic [COUNT8_W-1:0] max_attempts_q;
  logic [MS_W-1:0]     lockout_time_q;
  logic [MS_W-1:0]     unlock_time_q;
  logic [ANGLE_W-1:0]  closed_angle_q;
  logic [ANGLE_W-1:0]  open_angle_q;

  // lock state
  logic [MODE_W-1:0]   mode_q, mode_d;
  logic [DigitsW-1:0]  entry_q, entry_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [COUNT8_W-1:0] wrong_q, wrong_d;
  logic [MS_W-1:0]     unlock_left_q, unlock_left_d;
  logic [MS_W-1:0]     lockout_left_q, lockout_left_d;

  // result slots
  logic                slot0_q, slot1_q;
  logic [EVENT_W-1:0]  ev0_q, ev1_q;
  logic                last0_q;

  logic                in_accept, out_pop;
  logic [1:0]          n_res;
  logic [EVENT_W-1:0]  ev0, ev1;
  logic [CntW-1:0]     n_eff;
  logic                do_submit, mismatch, correct;
  logic [DigitsW-1:0]  sub_entry, dig_entry;
  logic [CntW-1:0]     sub_count, dig_count;
  logic [COUNT8_W-1:0] wrong_inc;
  logic [MS_W-1:0]     unlock_sub, lockout_sub;

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = slot0_q;
  assign out_pop     = slot0_q && !out_stall_i;
  assign in_stall_o  = slot1_q || (slot0_q && out_stall_i);
  assign in_accept   = in_valid_i && !in_stall_o;

  always_comb begin
    if (pin_length_q == '0) begin
      n_eff = CntW'(1);
    end else if (pin_length_q > PLEN_W'(MaxPinDigits)) begin
      n_eff = CntW'(MaxPinDigits);
    end else begin
      n_eff = CntW'(pin_length_q);
    end
  end

  // entry with the pressed digit added
  always_comb begin
    dig_entry = entry_q;
    for (int i = 0; i < MaxPinDigits; i++) begin
      if (count_q == CntW'(i)) begin
        dig_entry[4*i +: 4] = key_char_i[3:0];
      end
    end
    dig_count = (count_q < CntW'(MaxPinDigits)) ? count_q + CntW'(1) : count_q;
  end

  always_comb begin
    mismatch = 1'b0;
    for (int i = 0; i < MaxPinDigits; i++) begin
      if ((CntW'(i) < n_eff) && (sub_entry[4*i +: 4] != pin_code_q[4*i +: 4])) begin
        mismatch = 1'b1;
      end
    end
    correct = (sub_count == n_eff) && !mismatch;
  end

  assign wrong_inc   = (wrong_q != '1) ? wrong_q + COUNT8_W'(1) : wrong_q;
  assign unlock_sub  = (unlock_left_q > elapsed_ms_i) ? unlock_left_q - elapsed_ms_i : '0;
  assign lockout_sub = (lockout_left_q > elapsed_ms_i) ? lockout_left_q - elapsed_ms_i : '0;

  always_comb begin
    mode_d         = mode_q;
    entry_d        = entry_q;
    count_d        = count_q;
    wrong_d        = wrong_q;
    unlock_left_d  = unlock_left_q;
    lockout_left_d = lockout_left_q;
    n_res          = 2'd0;
    ev0            = EV_UNLOCK_PIN;
    ev1            = EV_UNLOCK_PIN;
    do_submit      = 1'b0;
    sub_entry      = entry_q;
    sub_count      = count_q;
    case (func_i)
      FUNC_KEY: begin
        if (mode_q == MODE_LOCKED || mode_q == MODE_ALARM) begin
          if (key_char_i == KEY_STAR) begin
            entry_d = '0;
            count_d = '0;
          end else if (key_char_i == KEY_HASH) begin
            do_submit = 1'b1;
          end else if (key_char_i inside {[KEY_0:KEY_9]}) begin
            entry_d   = dig_entry;
            count_d   = dig_count;
            sub_entry = dig_entry;
            sub_count = dig_count;
            do_submit = (dig_count >= n_eff);
          end
        end
      end
      FUNC_DOOR_OPEN: begin
        if (mode_q == MODE_LOCKED) begin
          mode_d = MODE_ALARM;
          ev0    = EV_INTRUSION;
          n_res  = 2'd1;
        end else if (mode_q == MODE_UNLOCKED) begin
          ev0   = EV_ENTRY;
          n_res = 2'd1;
        end
      end
      FUNC_REMOTE_OPEN: begin
        if (mode_q == MODE_LOCKOUT) begin
          ev0   = EV_REMOTE_DENIED;
          n_res = 2'd1;
        end else if (mode_q != MODE_UNLOCKED) begin
          wrong_d       = '0;
          mode_d        = MODE_UNLOCKED;
          unlock_left_d = unlock_time_q;
          ev0           = EV_UNLOCK_REMOTE;
          n_res         = 2'd1;
        end
      end
      FUNC_REMOTE_CLR: begin
        if (mode_q == MODE_ALARM) begin
          mode_d = MODE_LOCKED;
          ev0    = EV_ALARM_CLR_REM;
          n_res  = 2'd1;
        end
      end
      FUNC_TICK: begin
        if (mode_q == MODE_UNLOCKED) begin
          unlock_left_d = unlock_sub;
          if (unlock_sub == '0) begin
            mode_d = MODE_LOCKED;
            ev0    = EV_RELOCKED;
            n_res  = 2'd1;
          end
        end else if (mode_q == MODE_LOCKOUT) begin
          lockout_left_d = lockout_sub;
          if (lockout_sub == '0) begin
            mode_d  = MODE_LOCKED;
            wrong_d = '0;
            ev0     = EV_LOCKOUT_CLR;
            n_res   = 2'd1;
          end
        end
      end
      default: begin
      end
    endcase

    if (do_submit) begin
      entry_d = '0;
      count_d = '0;
      if (mode_q == MODE_ALARM) begin
        if (correct) begin
          wrong_d       = '0;
          mode_d        = MODE_UNLOCKED;
          unlock_left_d = unlock_time_q;
          ev0           = EV_ALARM_CLR_PIN;
          ev1           = EV_UNLOCK_PIN;
          n_res         = 2'd2;
        end
      end else if (correct) begin
        wrong_d       = '0;
        mode_d        = MODE_UNLOCKED;
        unlock_left_d = unlock_time_q;
        ev0           = EV_UNLOCK_PIN;
        n_res         = 2'd1;
      end else begin
        wrong_d = wrong_inc;
        ev0     = EV_WRONG_PIN;
        n_res   = 2'd1;
        if (wrong_inc >= max_attempts_q) begin
          mode_d         = MODE_LOCKOUT;
          lockout_left_d = lockout_time_q;
          ev1            = EV_LOCKOUT;
          n_res          = 2'd2;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q         <= MODE_LOCKED;
      entry_q        <= '0;
      count_q        <= '0;
      wrong_q        <= '0;
      unlock_left_q  <= '0;
      lockout_left_q <= '0;
    end else if (in_accept) begin
      mode_q         <= mode_d;
      entry_q        <= entry_d;
      count_q        <= count_d;
      wrong_q        <= wrong_d;
      unlock_left_q  <= unlock_left_d;
      lockout_left_q <= lockout_left_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot0_q <= 1'b0;
      slot1_q <= 1'b0;
    end else if (in_accept) begin
      slot0_q <= (n_res != 2'd0);
      slot1_q <= (n_res == 2'd2);
    end else if (out_pop) begin
      slot0_q <= slot1_q;
      slot1_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      ev0_q   <= ev0;
      ev1_q   <= ev1;
      last0_q <= (n_res == 2'd1);
    end else if (out_pop) begin
      ev0_q   <= ev1_q;
      last0_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pin_code_q     <= '0;
      pin_length_q   <= PLEN_W'(4);
      max_attempts_q <= COUNT8_W'(3);
      lockout_time_q <= MS_W'(30000);
      unlock_time_q  <= MS_W'(5000);
      closed_angle_q <= '0;
      open_angle_q   <= ANGLE_W'(90);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_PIN_CODE:     pin_code_q     <= cfg_data_i[PIN_W-1:0];
        REG_PIN_LENGTH:   pin_length_q   <= cfg_data_i[PLEN_W-1:0];
        REG_MAX_ATTEMPTS: max_attempts_q <= cfg_data_i[COUNT8_W-1:0];
        REG_LOCKOUT_TIME: lockout_time_q <= cfg_data_i[MS_W-1:0];
        REG_UNLOCK_TIME:  unlock_time_q  <= cfg_data_i[MS_W-1:0];
        REG_CLOSED_ANGLE: closed_angle_q <= cfg_data_i[ANGLE_W-1:0];
        REG_OPEN_ANGLE:   open_angle_q   <= cfg_data_i[ANGLE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // shared fields come from the state left by the item
  assign event_code_o     = ev0_q;
  assign last_o           = last0_q;
  assign attempts_left_o  = (max_attempts_q > wrong_q) ? max_attempts_q - wrong_q : '0;
  assign lockout_report_o = (ev0_q == EV_LOCKOUT) ? lockout_time_q : '0;
  assign bolt_angle_o     = (mode_q == MODE_UNLOCKED) ? open_angle_q : closed_angle_q;
  assign lock_mode_o      = mode_q;

  a_slot_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot1_q |-> slot0_q)
    else $error("second result pending without first");

  a_no_accept_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot1_q |-> !in_accept)
    else $error("item taken while a result pair is pending");

  a_pair_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_pop && slot1_q) |=> (out_valid_o && last_o))
    else $error("second result of a pair lost");

  a_lockout_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && event_code_o == EV_LOCKOUT) |-> (mode_q == MODE_LOCKOUT && last_o))
    else $error("lockout beat outside lockout mode");

  a_first_of_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot1_q |-> !last_o)
    else $error("first beat of a pair marked last");

endmodule
